/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, takes the new entry, its left
// neighbor on insert or its right neighbor on remove.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_ge,
	input  spq_pkg::entry_t    right_entry,
	output spq_pkg::entry_t    entry,
	output logic               ge
);
	import spq_pkg::*;

	entry_t entry_q;

	// at or past the insert point: slot empty or its priority not below the new one
	assign ge    = !(occupied && (entry_q.prio < new_entry.prio));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && ge) begin
			if (left_ge) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= new_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each request beat is an insert (mode 0) or a remove of the front entry
// (mode 1) and yields exactly one response beat. Entries stay sorted by
// ascending priority in a row of CAPACITY cells; an insert goes ahead of the
// first entry with equal or greater priority, so equal priorities leave newest
// first. Every cell compares its own priority with the incoming one in
// parallel, so one request is taken per cycle; the only wait comes from the
// single response register when the response side stalls. Insert on a full
// queue returns status full, remove on an empty one returns status empty,
// both with zero data. Occupancy shows the low 5 bits of the entry count.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               mode,
	input  logic signed [31:0] item_value,
	input  logic signed [15:0] item_priority,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic signed [15:0] out_priority,
	output logic [4:0]         occupancy
);
	import spq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	entry_t        out_q;
	logic [4:0]    occ_q;

	entry_t     new_entry;
	entry_t     cell_entry [CAPACITY];
	logic       cell_ge    [CAPACITY];
	cell_ctrl_t ctrl;
	logic       accept;
	logic       full;
	logic       empty;
	logic [1:0] status_nxt;
	entry_t     out_nxt;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);

	assign new_entry.value = item_value;
	assign new_entry.prio  = item_priority;

	assign ctrl.ins = accept && (mode == MODE_INSERT) && !full;
	assign ctrl.rem = accept && (mode == MODE_REMOVE) && !empty;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		out_nxt    = '0;
		if (mode == MODE_INSERT) begin
			if (full) begin
				status_nxt = ST_FULL;
			end else begin
				count_nxt = count_q + 1'b1;
			end
		end else begin
			if (empty) begin
				status_nxt = ST_EMPTY;
			end else begin
				count_nxt = count_q - 1'b1;
				out_nxt   = cell_entry[0];
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t lft_e;
		logic   lft_ge;
		entry_t rgt_e;

		if (i == 0) begin : g_first
			assign lft_e  = new_entry;
			assign lft_ge = 1'b0;
		end else begin : g_mid
			assign lft_e  = cell_entry[i-1];
			assign lft_ge = cell_ge[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rgt_e = '0;
		end else begin : g_inner
			assign rgt_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > CW'(i)),
			.new_entry  (new_entry),
			.left_entry (lft_e),
			.left_ge    (lft_ge),
			.right_entry(rgt_e),
			.entry      (cell_entry[i]),
			.ge         (cell_ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			out_q    <= out_nxt;
			occ_q    <= 5'(count_nxt);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign out_value    = out_q.value;
	assign out_priority = out_q.prio;
	assign occupancy    = occ_q;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// Request beats come from a backlog that the stimulus process fills. A driver
// offers them and a monitor checks response beats. On each accepted request
// the monitor updates a shadow sorted queue and records the response that is
// due. A directed opening covers an empty remove, extreme values and
// priorities, equal priorities, filling to capacity and an insert when full.
// Random bursts with insert/remove bias follow, under several idle and stall
// mixes, with long response hold-offs that back the queue up.
// ----------------------------------------------------------------------------
module tb_top;
	import spq_pkg::*;

	localparam int   HOLD_CYCLES = 120;
	localparam int   STUCK_LIMIT = 2000;
	localparam int   BURST_ITEMS = 345;

	typedef struct {
		logic               mode;
		logic signed [31:0] value;
		logic signed [15:0] prio;
	} req_beat_t;

	typedef struct {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic signed [15:0] prio;
		logic [4:0]         occ;
	} rsp_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               mode = MODE_INSERT;
	logic signed [31:0] item_value = '0;
	logic signed [15:0] item_priority = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic signed [31:0] out_value;
	logic signed [15:0] out_priority;
	logic [4:0]         occupancy;

	req_beat_t      req_backlog[$];
	entry_t         shadow_entries[$];
	rsp_beat_t      due_responses[$];
	req_beat_t      next_req;
	rsp_beat_t      want;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_arm      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	bit req_taken     = 1'b0;
	int stuck_cycles  = 0;

	int n_queued   = 0;
	int n_accepted = 0;
	int n_checked  = 0;
	int n_errors   = 0;
	int n_inserts  = 0;
	int n_removes  = 0;
	int n_full     = 0;
	int n_empty    = 0;
	int peak_occ   = 0;

	sorted_priority_queue i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.mode         (mode),
		.item_value   (item_value),
		.item_priority(item_priority),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 100)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// shadow of the sorted queue; returns the response this beat is due
	function automatic rsp_beat_t serve_request(input logic m, input logic signed [31:0] v,
			input logic signed [15:0] p);
		rsp_beat_t r;
		entry_t    e;
		int        pos;
		r.status = ST_DONE;
		r.value  = '0;
		r.prio   = '0;
		if (m == MODE_INSERT) begin
			if (shadow_entries.size() >= CAPACITY_DEF) begin
				r.status = ST_FULL;
				n_full++;
			end else begin
				pos = 0;
				while (pos < shadow_entries.size() && shadow_entries[pos].prio < p)
					pos++;
				e.value = v;
				e.prio  = p;
				shadow_entries.insert(pos, e);
				n_inserts++;
			end
		end else begin
			if (shadow_entries.size() == 0) begin
				r.status = ST_EMPTY;
				n_empty++;
			end else begin
				e = shadow_entries.pop_front();
				r.value = e.value;
				r.prio  = e.prio;
				n_removes++;
			end
		end
		r.occ = 5'(shadow_entries.size());
		if (shadow_entries.size() > peak_occ)
			peak_occ = shadow_entries.size();
		return r;
	endfunction

	task automatic push_req(input logic m, input logic signed [31:0] v,
			input logic signed [15:0] p);
		req_beat_t b;
		b.mode  = m;
		b.value = v;
		b.prio  = p;
		req_backlog.push_back(b);
		n_queued++;
	endtask

	// bursts with a varying insert/remove mix, most biased one way, so the queue swings full and empty
	task automatic add_random_bursts(input int count);
		int                 left;
		int                 len;
		int                 ins_pct;
		int                 k;
		logic               m;
		logic signed [15:0] p;
		left = count;
		while (left > 0) begin
			len = $urandom_range(40, 8);
			if (len > left)
				len = left;
			case ($urandom_range(3))
				0: ins_pct = 15;
				1: ins_pct = 50;
				2: ins_pct = 65;
				default: ins_pct = 90;
			endcase
			for (k = 0; k < len; k++) begin
				m = ($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_REMOVE;
				case ($urandom_range(4))
					0, 1: begin
						p = $signed(16'($urandom_range(6)));
						p = p - 16'sd3;
					end
					2: p = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
					default: p = $signed(16'($urandom));
				endcase
				push_req(m, $urandom, p);
			end
			left -= len;
		end
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || due_responses.size() != 0)
			@(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			req_taken = 1'b0;
			if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = req_backlog.pop_front();
				req_valid     <= 1'b1;
				mode          <= next_req.mode;
				item_value    <= next_req.value;
				item_priority <= next_req.prio;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response side stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_arm != hold_seen) begin
			hold_seen = hold_arm;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				due_responses.push_back(serve_request(mode, item_value, item_priority));
				req_taken = 1'b1;
				n_accepted++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_responses.size() == 0) begin
					report_mismatch("response beat with nothing due");
				end else begin
					want = due_responses.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d expected %0d",
							status, want.status));
					if (out_value !== want.value)
						report_mismatch($sformatf("out_value got %0d expected %0d",
							out_value, want.value));
					if (out_priority !== want.prio)
						report_mismatch($sformatf("out_priority got %0d expected %0d",
							out_priority, want.prio));
					if (occupancy !== want.occ)
						report_mismatch($sformatf("occupancy got %0d expected %0d",
							occupancy, want.occ));
				end
				n_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", STUCK_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int ph;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed opening
		push_req(MODE_REMOVE, 32'sd77, 16'sd9);
		push_req(MODE_INSERT, 32'sd0, 16'sd5);
		push_req(MODE_INSERT, 32'sh7fffffff, 16'sh7fff);
		push_req(MODE_INSERT, 32'sh80000000, 16'sh8000);
		push_req(MODE_INSERT, -32'sd1, 16'sd5);
		push_req(MODE_INSERT, 32'sd1, 16'sd100);
		push_req(MODE_INSERT, 32'sd2, 16'sd100);
		push_req(MODE_INSERT, 32'sd3, 16'sd100);
		push_req(MODE_INSERT, 32'sd4, -16'sd5);
		push_req(MODE_INSERT, 32'sh55555555, -16'sd32767);
		push_req(MODE_INSERT, 32'shaaaaaaaa, 16'sd32766);
		push_req(MODE_INSERT, 32'sd7, 16'sd0);
		push_req(MODE_INSERT, 32'sd8, 16'sd50);
		push_req(MODE_INSERT, 32'sd9, 16'sd200);
		push_req(MODE_INSERT, 32'sd10, -16'sd100);
		push_req(MODE_INSERT, 32'sd11, 16'sd1);
		push_req(MODE_INSERT, 32'sd12, 16'sh7fff);
		push_req(MODE_INSERT, 32'sd13, 16'sh8000);
		repeat (7)
			push_req(MODE_REMOVE, $urandom, $signed(16'($urandom)));
		wait_drained();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase
			if (ph == 0 || ph == 3)
				hold_arm++;
			add_random_bursts(BURST_ITEMS);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (due_responses.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
		$display("covered %0d request beats: %0d inserts, %0d removes, %0d full, %0d empty",
			n_accepted, n_inserts, n_removes, n_full, n_empty);
		$display("peak occupancy %0d of %0d, %0d response beats checked, %0d mismatches",
			peak_occ, CAPACITY_DEF, n_checked, n_errors);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
